/* rtl/bswg_pkg.sv */
// shared types, constants and tables of the beam steering weight generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bswg_pkg;

    localparam int DIM_W               = 7;
    localparam int CFG_IDX_W           = 8;
    localparam int OFF_W               = 32;
    localparam int EL_W                = 16;
    localparam int WGT_W               = 16;
    localparam int DEFAULT_MAX_PER_DIM = 64;
    localparam int DEFAULT_QUEUE_DEPTH = 4;
    localparam int CORDIC_STEPS        = 20;
    localparam int SQRT_STEPS          = 32;
    localparam int DIV_STEPS           = 31;
    localparam int AMP_DIV_STEPS       = 61;

    localparam logic [31:0]          GAIN_COMP = 32'd2608131496;
    localparam logic [DIM_W-1:0]     DIM_RESET = 7'd8;
    localparam logic [CFG_IDX_W-1:0] REG_DIM1  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM2  = 8'd1;

    typedef enum logic [1:0] {
        AMP_IDLE,
        AMP_DIV,
        AMP_SQRT,
        AMP_MUL
    } amp_state_t;

    // normalized offset magnitudes plus element data, one queue entry
    typedef struct packed {
        logic [2:0][31:0]     mag;
        logic [2:0]           neg;
        logic                 zero;
        logic [2:0][EL_W-1:0] el;
        logic                 last;
    } item_t;

    // amplitude unit status toward the datapath
    typedef struct packed {
        logic        busy;
        logic [31:0] x0;
    } amp_t;

    // cordic arctangent table in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        unique case (k)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/bswg_ifs.sv */
// channel interfaces: input item, output weight and register write
// depends on bswg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bswg_item_if;
    import bswg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic signed [OFF_W-1:0] offset_z;
    logic signed [EL_W-1:0]  element_x;
    logic signed [EL_W-1:0]  element_y;
    logic signed [EL_W-1:0]  element_z;
    logic                    last_element;

    modport source (
        output valid, offset_x, offset_y, offset_z, element_x, element_y, element_z,
        output last_element,
        input  ready
    );
    modport sink (
        input  valid, offset_x, offset_y, offset_z, element_x, element_y, element_z,
        input  last_element,
        output ready
    );
endinterface

interface bswg_weight_if;
    import bswg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [WGT_W-1:0] weight_real;
    logic signed [WGT_W-1:0] weight_imag;
    logic                    last_weight;

    modport source (output valid, weight_real, weight_imag, last_weight, input ready);
    modport sink (input valid, weight_real, weight_imag, last_weight, output ready);
endinterface

interface bswg_cfg_if;
    import bswg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/bswg_front.sv */
// front end: takes item beats, forms offset magnitudes and normalizes them
// depends on bswg_pkg and bswg_item_if
`timescale 1ns / 1ps
`default_nettype none

module bswg_front (
    input  logic            clk,
    input  logic            rst_n,
    bswg_item_if.sink       item,
    input  logic            hold,
    output logic            push_valid,
    input  logic            push_ready,
    output bswg_pkg::item_t push_data
);
    import bswg_pkg::*;

    logic             valid_reg;
    item_t            data_reg;
    item_t            data_next;
    logic [2:0][31:0] mag;
    logic [31:0]      mmax;
    logic [4:0]       msb;
    logic [4:0]       shamt;
    logic             take;

    assign item.ready = (!valid_reg || push_ready) && !hold;
    assign take       = item.valid && item.ready;
    assign push_valid = valid_reg;
    assign push_data  = data_reg;

    always_comb
    begin
        mag[0] = item.offset_x[OFF_W-1] ? 32'(-item.offset_x) : 32'(item.offset_x);
        mag[1] = item.offset_y[OFF_W-1] ? 32'(-item.offset_y) : 32'(item.offset_y);
        mag[2] = item.offset_z[OFF_W-1] ? 32'(-item.offset_z) : 32'(item.offset_z);
        mmax = mag[0];
        if (mag[1] > mmax)
        begin
            mmax = mag[1];
        end
        if (mag[2] > mmax)
        begin
            mmax = mag[2];
        end
        msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mmax[i])
            begin
                msb = 5'(i);
            end
        end
        // bring the largest magnitude up to at least 2^30
        shamt = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
        for (int k = 0; k < 3; k++)
        begin
            data_next.mag[k] = mag[k] << shamt;
        end
        data_next.neg  = {item.offset_z[OFF_W-1], item.offset_y[OFF_W-1],
                          item.offset_x[OFF_W-1]};
        data_next.zero = (mmax == 32'd0);
        data_next.el   = {item.element_z, item.element_y, item.element_x};
        data_next.last = item.last_element;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bswg_queue.sv */
// short fifo between the front end and the datapath
// depends on bswg_pkg
`timescale 1ns / 1ps
`default_nettype none

module bswg_queue #(
    parameter int DEPTH = bswg_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  bswg_pkg::item_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bswg_pkg::item_t pop_data
);
    import bswg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/bswg_amp.sv */
// register file and amplitude sequencer: 2^60 / n, square root, gain scaling
// depends on bswg_pkg and bswg_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module bswg_amp #(
    parameter int MAX_PER_DIM = bswg_pkg::DEFAULT_MAX_PER_DIM
) (
    input  logic           clk,
    input  logic           rst_n,
    bswg_cfg_if.sink       cfg,
    output bswg_pkg::amp_t amp
);
    import bswg_pkg::*;

    localparam int NW = 2 * DIM_W;

    amp_state_t       state_reg;
    amp_state_t       state_next;
    logic [DIM_W-1:0] dim1_reg;
    logic [DIM_W-1:0] dim2_reg;
    logic [5:0]       cnt_reg;
    logic [5:0]       cnt_next;
    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    rem_next;
    logic [59:0]      quo_reg;
    logic [59:0]      quo_next;
    logic [63:0]      sn_reg;
    logic [63:0]      sn_next;
    logic [63:0]      sr_reg;
    logic [63:0]      sr_next;
    logic [31:0]      x_reg;
    logic [31:0]      x_next;
    logic             wr;
    logic             start;
    logic             last_div;
    logic             last_sqrt;
    logic [NW-1:0]    n;
    logic [NW:0]      shifted;
    logic             qbit;
    logic [63:0]      bitv;
    logic [63:0]      prod;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            return DIM_W'(1);
        end
        if (int'(d) > MAX_PER_DIM)
        begin
            return DIM_W'(MAX_PER_DIM);
        end
        return d;
    endfunction

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;
    assign start     = wr && (cfg.index == REG_DIM1 || cfg.index == REG_DIM2);
    assign last_div  = (cnt_reg == 6'(AMP_DIV_STEPS - 1));
    assign last_sqrt = (cnt_reg == 6'(SQRT_STEPS - 1));
    assign amp.busy  = (state_reg != AMP_IDLE);
    assign amp.x0    = x_reg;

    always_comb
    begin
        n       = NW'(clamp_dim(dim1_reg)) * NW'(clamp_dim(dim2_reg));
        shifted = {rem_reg, (cnt_reg == 6'd0)};
        qbit    = (shifted >= {1'b0, n});
        bitv    = 64'd1 << (7'd62 - {cnt_reg, 1'b0});
        prod    = {32'd0, sr_reg[31:0]} * {32'd0, GAIN_COMP};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AMP_IDLE: state_next = AMP_IDLE;
            AMP_DIV:
            begin
                if (last_div)
                begin
                    state_next = AMP_SQRT;
                end
            end
            AMP_SQRT:
            begin
                if (last_sqrt)
                begin
                    state_next = AMP_MUL;
                end
            end
            AMP_MUL:  state_next = AMP_IDLE;
            default:  state_next = AMP_IDLE;
        endcase
        if (start)
        begin
            state_next = AMP_DIV;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        sn_next  = sn_reg;
        sr_next  = sr_reg;
        x_next   = x_reg;
        unique case (state_reg)
            AMP_IDLE: cnt_next = cnt_reg;
            AMP_DIV:
            begin
                cnt_next = last_div ? 6'd0 : cnt_reg + 1'b1;
                rem_next = qbit ? NW'(shifted - {1'b0, n}) : NW'(shifted);
                quo_next = {quo_reg[58:0], qbit};
                if (last_div)
                begin
                    sn_next = {3'd0, quo_reg, qbit};
                    sr_next = '0;
                end
            end
            AMP_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (sn_reg >= sr_reg + bitv)
                begin
                    sn_next = sn_reg - (sr_reg + bitv);
                    sr_next = (sr_reg >> 1) + bitv;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
            end
            AMP_MUL:  x_next = 32'((prod + 64'h8000_0000) >> 32);
            default:  cnt_next = cnt_reg;
        endcase
        if (start)
        begin
            cnt_next = '0;
            rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AMP_DIV;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dim1_reg  <= DIM_RESET;
            dim2_reg  <= DIM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            if (wr && cfg.index == REG_DIM1)
            begin
                dim1_reg <= cfg.data;
            end
            if (wr && cfg.index == REG_DIM2)
            begin
                dim2_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        sn_reg  <= sn_next;
        sr_reg  <= sr_next;
        x_reg   <= x_next;
    end

endmodule

`default_nettype wire

/* rtl/bswg_back.sv */
// datapath: norm square root, direction divide, phase and cordic rotation
// depends on bswg_pkg and bswg_weight_if
`timescale 1ns / 1ps
`default_nettype none

module bswg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  bswg_pkg::item_t pop_data,
    input  bswg_pkg::amp_t  amp,
    bswg_weight_if.source   weight
);
    import bswg_pkg::*;

    localparam int ZW = 34;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic signed [ZW:0] Q15_ROUND = 35'sd16384;
    localparam logic signed [ZW:0] Q15_MAX   = 35'sd32767;
    localparam logic signed [ZW:0] Q15_MIN   = -35'sd32768;

    logic adv;

    logic             sq_valid_reg;
    logic [2:0][63:0] sq_reg;
    item_t            sq_item_reg;

    logic [SQRT_STEPS:0] rv_reg;
    logic [63:0]         rn_reg [SQRT_STEPS+1];
    logic [63:0]         rr_reg [SQRT_STEPS+1];
    item_t               ri_reg [SQRT_STEPS+1];
    logic [63:0]         rn_next [SQRT_STEPS];
    logic [63:0]         rr_next [SQRT_STEPS];

    logic [DIV_STEPS:0] dv_reg;
    logic [2:0][62:0]   drem_reg [DIV_STEPS+1];
    logic [2:0][30:0]   dq_reg   [DIV_STEPS+1];
    logic [31:0]        dd_reg   [DIV_STEPS+1];
    item_t              di_reg   [DIV_STEPS+1];
    logic [2:0][62:0]   drem_next [DIV_STEPS];
    logic [2:0][30:0]   dq_next   [DIV_STEPS];
    logic [62:0]        dtrial    [DIV_STEPS];
    logic [2:0][62:0]   drem_init;
    logic [31:0]        r_root;

    logic                 u_valid_reg;
    logic [2:0][31:0]     u_reg;
    logic [2:0][31:0]     u_next;
    logic [2:0][EL_W-1:0] ue_reg;
    logic                 ulast_reg;

    logic             p_valid_reg;
    logic [2:0][47:0] p_reg;
    logic [2:0][47:0] p_next;
    logic             plast_reg;

    logic [49:0] dot;
    logic [49:0] negdot;
    logic [31:0] ang;
    logic [31:0] qsum;
    logic [1:0]  quad;
    logic [31:0] dres;

    logic [CORDIC_STEPS:0]  cv_reg;
    logic signed [ZW-1:0]   cx_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cy_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cz_reg [CORDIC_STEPS+1];
    logic [1:0]             cq_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]  cl_reg;
    logic signed [ZW-1:0]   cx_next [CORDIC_STEPS];
    logic signed [ZW-1:0]   cy_next [CORDIC_STEPS];
    logic signed [ZW-1:0]   cz_next [CORDIC_STEPS];

    logic signed [ZW-1:0] re;
    logic signed [ZW-1:0] im;
    logic                 out_valid_reg;
    logic [WGT_W-1:0]     wr_reg;
    logic [WGT_W-1:0]     wi_reg;
    logic                 wl_reg;

    function automatic logic [63:0] sq_bit(input int k);
        return 64'd1 << (62 - 2 * k);
    endfunction

    function automatic logic signed [ZW-1:0] atan_z(input int k);
        return $signed({2'b00, atan_turn(k)});
    endfunction

    function automatic logic [WGT_W-1:0] to_q15(input logic signed [ZW-1:0] v);
        logic signed [ZW:0] t;
        t = $signed({v[ZW-1], v}) + Q15_ROUND;
        t = t >>> 15;
        if (t > Q15_MAX)
        begin
            return 16'h7FFF;
        end
        if (t < Q15_MIN)
        begin
            return 16'h8000;
        end
        return t[WGT_W-1:0];
    endfunction

    assign adv          = !out_valid_reg || weight.ready;
    assign pop_ready    = adv;
    assign weight.valid = out_valid_reg;
    assign weight.weight_real = wr_reg;
    assign weight.weight_imag = wi_reg;
    assign weight.last_weight = wl_reg;

    // square root of the sum of squares, one result bit per stage
    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rn_next[k] = rn_reg[k];
            rr_next[k] = rr_reg[k] >> 1;
            if (rn_reg[k] >= rr_reg[k] + sq_bit(k))
            begin
                rn_next[k] = rn_reg[k] - (rr_reg[k] + sq_bit(k));
                rr_next[k] = (rr_reg[k] >> 1) + sq_bit(k);
            end
        end
    end

    // rounded divide of each magnitude by the norm
    always_comb
    begin
        r_root = rr_reg[SQRT_STEPS][31:0];
        for (int j = 0; j < 3; j++)
        begin
            drem_init[j] = 63'({ri_reg[SQRT_STEPS].mag[j], 30'd0}) + 63'(r_root >> 1);
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dtrial[k]    = 63'(dd_reg[k]) << (30 - k);
            drem_next[k] = drem_reg[k];
            dq_next[k]   = dq_reg[k];
            for (int j = 0; j < 3; j++)
            begin
                if (drem_reg[k][j] >= dtrial[k])
                begin
                    drem_next[k][j]      = drem_reg[k][j] - dtrial[k];
                    dq_next[k][j][30-k]  = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            u_next[j] = di_reg[DIV_STEPS].neg[j] ? 32'd0 - {1'b0, dq_reg[DIV_STEPS][j]}
                                                 : {1'b0, dq_reg[DIV_STEPS][j]};
        end
        if (di_reg[DIV_STEPS].zero)
        begin
            u_next = {32'h4000_0000, 32'd0, 32'd0};
        end
        for (int j = 0; j < 3; j++)
        begin
            p_next[j] = {{16{u_reg[j][31]}}, u_reg[j]} * {{32{ue_reg[j][EL_W-1]}}, ue_reg[j]};
        end
    end

    // phase in turns, split into quarter turn and residual
    always_comb
    begin
        dot    = {{2{p_reg[0][47]}}, p_reg[0]} + {{2{p_reg[1][47]}}, p_reg[1]}
               + {{2{p_reg[2][47]}}, p_reg[2]};
        negdot = 50'd32 - dot;
        ang    = negdot[37:6];
        qsum   = ang + 32'h2000_0000;
        quad   = qsum[31:30];
        dres   = ang - {quad, 30'd0};
    end

    always_comb
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (!cz_reg[k][ZW-1])
            begin
                cx_next[k] = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] - atan_z(k);
            end
            else
            begin
                cx_next[k] = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] + atan_z(k);
            end
        end
    end

    always_comb
    begin
        unique case (cq_reg[CORDIC_STEPS])
            QUAD_0:
            begin
                re = cx_reg[CORDIC_STEPS];
                im = cy_reg[CORDIC_STEPS];
            end
            QUAD_1:
            begin
                re = -cy_reg[CORDIC_STEPS];
                im = cx_reg[CORDIC_STEPS];
            end
            QUAD_2:
            begin
                re = -cx_reg[CORDIC_STEPS];
                im = -cy_reg[CORDIC_STEPS];
            end
            QUAD_3:
            begin
                re = cy_reg[CORDIC_STEPS];
                im = -cx_reg[CORDIC_STEPS];
            end
            default:
            begin
                re = cx_reg[CORDIC_STEPS];
                im = cy_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            rv_reg        <= '0;
            dv_reg        <= '0;
            u_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg  <= pop_valid;
            rv_reg        <= {rv_reg[SQRT_STEPS-1:0], sq_valid_reg};
            dv_reg        <= {dv_reg[DIV_STEPS-1:0], rv_reg[SQRT_STEPS]};
            u_valid_reg   <= dv_reg[DIV_STEPS];
            p_valid_reg   <= u_valid_reg;
            cv_reg        <= {cv_reg[CORDIC_STEPS-1:0], p_valid_reg};
            out_valid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= {32'd0, pop_data.mag[j]} * {32'd0, pop_data.mag[j]};
            end
            sq_item_reg <= pop_data;

            rn_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rr_reg[0] <= '0;
            ri_reg[0] <= sq_item_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rn_reg[k+1] <= rn_next[k];
                rr_reg[k+1] <= rr_next[k];
                ri_reg[k+1] <= ri_reg[k];
            end

            drem_reg[0] <= drem_init;
            dq_reg[0]   <= '0;
            dd_reg[0]   <= r_root;
            di_reg[0]   <= ri_reg[SQRT_STEPS];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                drem_reg[k+1] <= drem_next[k];
                dq_reg[k+1]   <= dq_next[k];
                dd_reg[k+1]   <= dd_reg[k];
                di_reg[k+1]   <= di_reg[k];
            end

            u_reg     <= u_next;
            ue_reg    <= di_reg[DIV_STEPS].el;
            ulast_reg <= di_reg[DIV_STEPS].last;
            p_reg     <= p_next;
            plast_reg <= ulast_reg;

            cx_reg[0] <= $signed({2'b00, amp.x0});
            cy_reg[0] <= '0;
            cz_reg[0] <= $signed({{2{dres[31]}}, dres});
            cq_reg[0] <= quad;
            cl_reg[0] <= plast_reg;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                cx_reg[k+1] <= cx_next[k];
                cy_reg[k+1] <= cy_next[k];
                cz_reg[k+1] <= cz_next[k];
                cq_reg[k+1] <= cq_reg[k];
                cl_reg[k+1] <= cl_reg[k];
            end

            wr_reg <= to_q15(re);
            wi_reg <= to_q15(im);
            wl_reg <= cl_reg[CORDIC_STEPS];
        end
    end

endmodule

`default_nettype wire

/* rtl/beam_steering_weight_generator_unit.sv */
// Steering weight generator: one complex Q1.15 weight per array element beat.
// A new element is taken every cycle while no output stall or amplitude update
// holds off the input; the weight passes through the front register, the queue,
// the 32-stage norm square root, the 31-stage direction divide and the 20-stage
// cordic. After reset and after each write of a dimension register the input is
// held off while the amplitude 1/sqrt(dim1*dim2) is recomputed bit-serially.
// Output stalls back up through the pipeline and the front queue.
// depends on bswg_pkg, bswg_ifs, bswg_front, bswg_queue, bswg_amp, bswg_back
`timescale 1ns / 1ps
`default_nettype none

module beam_steering_weight_generator_unit #(
    parameter int MAX_ELEMENTS_PER_DIM = bswg_pkg::DEFAULT_MAX_PER_DIM,
    parameter int QUEUE_DEPTH          = bswg_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    bswg_item_if.sink     item,
    bswg_weight_if.source weight,
    bswg_cfg_if.sink      cfg
);
    import bswg_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_data;
    amp_t  amp;

    bswg_amp #(
        .MAX_PER_DIM (MAX_ELEMENTS_PER_DIM)
    ) u_amp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .amp   (amp)
    );

    bswg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .hold       (amp.busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bswg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bswg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .amp       (amp),
        .weight    (weight)
    );

endmodule

`default_nettype wire
